[sv/ptsc_pkg.sv]
// ptsc_pkg: shared types and constants for the periodic temperature sensor converter
// no dependencies; used by periodic_temp_sensor_converter_unit

package ptsc_pkg;

	localparam int ADC_WIDTH_DEFAULT = 12;
	localparam int CODE_W            = 12;
	localparam int TEMP_W            = 16;
	localparam int INTERVAL_W        = 16;
	localparam int DEFAULT_INTERVAL  = 500;
	localparam int CAL_LIMIT         = 4096;

	// temperatures in 1/16 degree
	localparam int CAL_BASE_TEMP     = 480;    // 30 degrees
	localparam int CAL_SPAN_TEMP     = 1280;   // 110 - 30 degrees
	localparam int DS_SLOPE          = 21120;  // 3300 mV full scale / 2.5 mV * 16
	localparam int DS_OFFSET         = 4464;   // (760 / 2.5 - 25) * 16

	localparam int DIV_W             = 32;     // dividend / quotient width
	localparam int DEN_W             = 16;     // divisor before doubling

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_DONE = 2'd1,
		CMD_POLL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ENABLE   = 2'd0,
		REG_INTERVAL = 2'd1,
		REG_CAL_LOW  = 2'd2,
		REG_CAL_HIGH = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_LOAD,
		ST_DIV,
		ST_FINISH
	} state_t;

endpackage

[sv/periodic_temp_sensor_converter_unit.sv]
// periodic_temp_sensor_converter_unit: tick scheduler, sample store and temperature conversion
// depends on ptsc_pkg; one shared restoring divider under a small sequencer

// Each accepted beat gives exactly one result beat. Ticks, polls, unknown commands and beats
// taken while disabled are answered directly: the result is registered at the accepting edge.
// A finished conversion with sampling enabled steps through ST_SETUP to form the signed
// numerator, ST_LOAD to form the rounded dividend, ST_DIV for the bit-serial divider (one
// quotient bit a cycle) and ST_FINISH to sign, offset and saturate into the result register.
// item_stall is high for that whole time and while a result beat waits on a stalled receiver.
// Registers sit at byte addresses 0, 4, 8 and 12; the user must write them only while the
// block is idle, which the block itself does not enforce.

module periodic_temp_sensor_converter_unit #(
	parameter int ADC_WIDTH = ptsc_pkg::ADC_WIDTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [3:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// items
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [1:0]                        command,
	input  logic [ptsc_pkg::CODE_W-1:0]       sample_code,
	// results
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              start_conversion,
	output logic signed [ptsc_pkg::TEMP_W-1:0] temperature,
	output logic                              fresh,
	output logic [ptsc_pkg::CODE_W-1:0]       last_code,
	output logic                              used_calibration
);

	localparam int CW       = ptsc_pkg::CODE_W;
	localparam int TW       = ptsc_pkg::TEMP_W;
	localparam int IW       = ptsc_pkg::INTERVAL_W;
	localparam int DW       = ptsc_pkg::DIV_W;
	localparam int NW       = ptsc_pkg::DEN_W;
	localparam int CNT_W    = $clog2(DW);
	localparam longint FULL_SCALE = (64'd1 << ADC_WIDTH) - 64'd1;
	localparam logic [CW-1:0] CODE_MASK = CW'((ADC_WIDTH >= CW) ? ((64'd1 << CW) - 64'd1)
		: FULL_SCALE);
	localparam logic signed [DW-1:0] DS_OFS = DW'(ptsc_pkg::DS_OFFSET * FULL_SCALE);
	localparam logic [NW-1:0] DS_DEN = NW'(FULL_SCALE);
	localparam logic [IW-1:0] ALL_ONES = '1;

	// configuration registers
	logic            enable_q;
	logic [IW-1:0]   interval_q;
	logic [CW-1:0]   cal_low_q;
	logic [CW-1:0]   cal_high_q;

	// block state
	logic [IW-1:0]   elapsed_q;
	logic [CW-1:0]   code_q;
	logic signed [TW-1:0] temp_q;
	logic            fresh_q;
	logic            cal_q;

	// divider datapath
	ptsc_pkg::state_t state_q, state_d;
	logic signed [DW-1:0] num_q;
	logic [NW-1:0]   den_q;
	logic            neg_q;
	logic [DW-1:0]   quo_q;
	logic [NW:0]     dvs_q;
	logic [NW:0]     rem_q;
	logic [CNT_W-1:0] cnt_q;

	// result register
	logic            res_valid_q;
	logic            res_start_q;
	logic            res_fresh_q;

	logic            cfg_wr;
	logic            accept;
	logic            out_busy;
	logic            conv_go;
	logic            finish_go;
	logic            load_now;
	logic            tick_start;
	logic [IW-1:0]   elapsed_inc;
	logic            cal_ok;
	logic [NW+1:0]   trial_rem;
	logic            trial_ge;
	logic signed [DW-1:0] num_cal;
	logic signed [DW-1:0] num_ds;
	logic [DW-1:0]   mag;
	logic signed [DW+1:0] t_full;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (ptsc_pkg::reg_idx_t'(paddr[3:2]))
			ptsc_pkg::REG_ENABLE:   prdata = {31'd0, enable_q};
			ptsc_pkg::REG_INTERVAL: prdata = {{(32-IW){1'b0}}, interval_q};
			ptsc_pkg::REG_CAL_LOW:  prdata = {{(32-CW){1'b0}}, cal_low_q};
			ptsc_pkg::REG_CAL_HIGH: prdata = {{(32-CW){1'b0}}, cal_high_q};
			default:                prdata = '0;
		endcase
	end

	// handshake and sequencer
	assign out_busy   = res_valid_q && result_stall;
	assign item_stall = (state_q != ptsc_pkg::ST_IDLE) || out_busy;
	assign accept     = item_valid && !item_stall;
	assign conv_go    = accept && (command == ptsc_pkg::CMD_DONE) && enable_q;

	always_comb begin
		state_d   = state_q;
		finish_go = 1'b0;
		case (state_q)
			ptsc_pkg::ST_IDLE:   if (conv_go) state_d = ptsc_pkg::ST_SETUP;
			ptsc_pkg::ST_SETUP:  state_d = ptsc_pkg::ST_LOAD;
			ptsc_pkg::ST_LOAD:   state_d = ptsc_pkg::ST_DIV;
			ptsc_pkg::ST_DIV:    if (cnt_q == '0) state_d = ptsc_pkg::ST_FINISH;
			ptsc_pkg::ST_FINISH: begin
				if (!out_busy) begin
					finish_go = 1'b1;
					state_d   = ptsc_pkg::ST_IDLE;
				end
			end
			default:             state_d = ptsc_pkg::ST_IDLE;
		endcase
	end

	assign load_now = (accept && !conv_go) || finish_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// tick scheduling
	assign elapsed_inc = (elapsed_q != ALL_ONES) ? elapsed_q + 1'b1 : elapsed_q;
	assign tick_start  = enable_q && (elapsed_inc >= interval_q);

	// numerator forms
	assign cal_ok  = (cal_low_q != '0) && (cal_high_q > cal_low_q)
		&& ({1'b0, cal_high_q} < (CW+1)'(ptsc_pkg::CAL_LIMIT));
	assign num_cal = DW'($signed({1'b0, code_q}) - $signed({1'b0, cal_low_q}))
		* DW'(ptsc_pkg::CAL_SPAN_TEMP);
	assign num_ds  = $signed(DW'(code_q) * DW'(ptsc_pkg::DS_SLOPE)) - DS_OFS;
	assign mag     = num_q[DW-1] ? DW'(-num_q) : DW'(num_q);

	// one restoring step
	assign trial_rem = {rem_q, quo_q[DW-1]};
	assign trial_ge  = trial_rem >= {1'b0, dvs_q};

	// sign, offset, saturate
	assign t_full = (neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}))
		+ (cal_q ? (DW+2)'(ptsc_pkg::CAL_BASE_TEMP) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			interval_q  <= IW'(ptsc_pkg::DEFAULT_INTERVAL);
			cal_low_q   <= '0;
			cal_high_q  <= '0;
			elapsed_q   <= ALL_ONES;
			code_q      <= '0;
			temp_q      <= '0;
			fresh_q     <= 1'b0;
			cal_q       <= 1'b0;
			res_valid_q <= 1'b0;
			res_start_q <= 1'b0;
			res_fresh_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_wr) begin
				case (ptsc_pkg::reg_idx_t'(paddr[3:2]))
					ptsc_pkg::REG_ENABLE: begin
						enable_q <= pwdata[0];
						if (pwdata[0]) elapsed_q <= ALL_ONES;
					end
					ptsc_pkg::REG_INTERVAL: begin
						interval_q <= (pwdata[IW-1:0] == '0) ?
							IW'(ptsc_pkg::DEFAULT_INTERVAL) : pwdata[IW-1:0];
					end
					ptsc_pkg::REG_CAL_LOW:  cal_low_q <= pwdata[CW-1:0];
					ptsc_pkg::REG_CAL_HIGH: cal_high_q <= pwdata[CW-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				res_start_q <= 1'b0;
				res_fresh_q <= 1'b0;
				case (command)
					ptsc_pkg::CMD_TICK: begin
						if (enable_q) begin
							elapsed_q   <= tick_start ? '0 : elapsed_inc;
							res_start_q <= tick_start;
						end
					end
					ptsc_pkg::CMD_DONE: begin
						if (enable_q) code_q <= sample_code & CODE_MASK;
					end
					ptsc_pkg::CMD_POLL: begin
						res_fresh_q <= fresh_q;
						fresh_q     <= 1'b0;
					end
					default: ;
				endcase
			end

			if (state_q == ptsc_pkg::ST_SETUP) cal_q <= cal_ok;
			if (state_q == ptsc_pkg::ST_LOAD) cnt_q <= CNT_W'(DW - 1);
			if (state_q == ptsc_pkg::ST_DIV) cnt_q <= cnt_q - 1'b1;

			if (finish_go) begin
				fresh_q <= 1'b1;
				if (t_full > (DW+2)'(signed'(32767)))
					temp_q <= TW'(32767);
				else if (t_full < -(DW+2)'(signed'(32768)))
					temp_q <= TW'(-32768);
				else
					temp_q <= t_full[TW-1:0];
			end

			if (load_now)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	// divider payload
	always_ff @(posedge clk) begin
		case (state_q)
			ptsc_pkg::ST_SETUP: begin
				num_q <= cal_ok ? num_cal : num_ds;
				den_q <= cal_ok ? NW'(cal_high_q - cal_low_q) : DS_DEN;
			end
			ptsc_pkg::ST_LOAD: begin
				neg_q <= num_q[DW-1];
				quo_q <= {mag[DW-2:0], 1'b0} + DW'(den_q);
				dvs_q <= {den_q, 1'b0};
				rem_q <= '0;
			end
			ptsc_pkg::ST_DIV: begin
				rem_q <= trial_ge ? (NW+1)'(trial_rem - {1'b0, dvs_q})
					: trial_rem[NW:0];
				quo_q <= {quo_q[DW-2:0], trial_ge};
			end
			default: ;
		endcase
	end

	assign result_valid     = res_valid_q;
	assign start_conversion = res_start_q;
	assign fresh            = res_fresh_q;
	assign temperature      = temp_q;
	assign last_code        = code_q;
	assign used_calibration = cal_q;

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptsc_pkg::ST_DIV && cnt_q == '0) |=> state_q == ptsc_pkg::ST_FINISH)
		else $error("divider did not finish after its last step");

	a_interval_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		interval_q != '0)
		else $error("sample interval register holds zero");

	a_conv_starts: assert property (@(posedge clk) disable iff (!arst_n)
		conv_go |=> (state_q == ptsc_pkg::ST_SETUP && !result_valid))
		else $error("accepted conversion did not enter the divider sequence");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(start_conversion && fresh))
		else $error("tick and poll flags both set on one result beat");

endmodule

[tb/sv/periodic_temp_sensor_converter_unit_checker.sv]
// checker for periodic_temp_sensor_converter_unit: follows register writes and item beats,
// predicts each result beat and compares it field by field with what the block sends
// depends on ptsc_pkg for the command and register codes

module periodic_temp_sensor_converter_unit_checker
	import ptsc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	input  logic                       item_valid,
	input  logic                       item_stall,
	input  logic [1:0]                 command,
	input  logic [CODE_W-1:0]          sample_code,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  logic                       start_conversion,
	input  logic signed [TEMP_W-1:0]   temperature,
	input  logic                       fresh,
	input  logic [CODE_W-1:0]          last_code,
	input  logic                       used_calibration,
	output int                         errors,
	output int                         pending,
	output int                         checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     ADC_BITS      = 12;
	localparam longint FULL_SCALE    = (64'd1 << ADC_BITS) - 1;
	localparam longint CAL_T_LOW     = 480;
	localparam longint CAL_T_SPAN    = 1280;
	localparam longint SHEET_SLOPE   = 21120;
	localparam longint SHEET_OFFSET  = 4464;
	localparam int     IVAL_DEFAULT  = 500;
	localparam int     CAL_CODE_LIM  = 4096;

	typedef struct {
		logic                     start;
		logic signed [TEMP_W-1:0] temp;
		logic                     fresh;
		logic [CODE_W-1:0]        code;
		logic                     cal;
	} reading_t;

	reading_t readings_due[$];
	reading_t next_reading;

	logic                     run_en;
	logic [15:0]              interval;
	logic [11:0]              cal_lo;
	logic [11:0]              cal_hi;
	logic [15:0]              ticks;
	logic [CODE_W-1:0]        code_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                     fresh_q;
	logic                     cal_q;

	initial begin
		errors = 0;
		checked = 0;
	end

	task report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	function automatic longint rounded_quotient(input longint num, input longint den);
		if (num >= 0)
			return (2 * num + den) / (2 * den);
		return -((-2 * num + den) / (2 * den));
	endfunction

	function automatic logic signed [TEMP_W-1:0] saturate(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[TEMP_W-1:0];
	endfunction

	task apply_write(input reg_idx_t idx, input logic [31:0] data);
		case (idx)
			REG_ENABLE: begin
				run_en = data[0];
				if (data[0])
					ticks = '1;
			end
			REG_INTERVAL: interval = (data[15:0] == 16'd0) ? 16'(IVAL_DEFAULT) : data[15:0];
			REG_CAL_LOW:  cal_lo = data[11:0];
			REG_CAL_HIGH: cal_hi = data[11:0];
			default: ;
		endcase
	endtask

	task convert_code(input logic [CODE_W-1:0] code);
		longint num;
		longint den;
		longint t;
		if (cal_lo != 12'd0 && cal_hi > cal_lo && int'(cal_hi) < CAL_CODE_LIM) begin
			num = CAL_T_SPAN * (longint'(code) - longint'(cal_lo));
			den = longint'(cal_hi) - longint'(cal_lo);
			t = CAL_T_LOW + rounded_quotient(num, den);
			cal_q = 1'b1;
		end else begin
			num = longint'(code) * SHEET_SLOPE - SHEET_OFFSET * FULL_SCALE;
			t = rounded_quotient(num, FULL_SCALE);
			cal_q = 1'b0;
		end
		temp_q = saturate(t);
	endtask

	task predict_step(input logic [1:0] cmd, input logic [CODE_W-1:0] code, output reading_t r);
		r.start = 1'b0;
		r.fresh = 1'b0;
		case (cmd_t'(cmd))
			CMD_TICK: begin
				if (run_en) begin
					if (ticks != 16'hFFFF)
						ticks = ticks + 16'd1;
					if (ticks >= interval) begin
						r.start = 1'b1;
						ticks = '0;
					end
				end
			end
			CMD_DONE: begin
				if (run_en) begin
					code_q = code & CODE_W'(FULL_SCALE);
					convert_code(code_q);
					fresh_q = 1'b1;
				end
			end
			CMD_POLL: begin
				r.fresh = fresh_q;
				fresh_q = 1'b0;
			end
			default: ;
		endcase
		r.temp = temp_q;
		r.code = code_q;
		r.cal = cal_q;
	endtask

	task compare_reading;
		reading_t want;
		if (readings_due.size() == 0) begin
			report_mismatch("result beat with nothing pending, temperature", temperature, 0);
		end else begin
			want = readings_due.pop_front();
			checked++;
			if (start_conversion !== want.start)
				report_mismatch("start_conversion", start_conversion, want.start);
			if (temperature !== want.temp)
				report_mismatch("temperature", temperature, want.temp);
			if (fresh !== want.fresh)
				report_mismatch("fresh", fresh, want.fresh);
			if (last_code !== want.code)
				report_mismatch("last_code", last_code, want.code);
			if (used_calibration !== want.cal)
				report_mismatch("used_calibration", used_calibration, want.cal);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_en = 1'b0;
			interval = 16'(IVAL_DEFAULT);
			cal_lo = '0;
			cal_hi = '0;
			ticks = '1;
			code_q = '0;
			temp_q = '0;
			fresh_q = 1'b0;
			cal_q = 1'b0;
			readings_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready)
				apply_write(reg_idx_t'(paddr[3:2]), pwdata);
			if (result_valid && !result_stall)
				compare_reading();
			if (item_valid && !item_stall) begin
				predict_step(command, sample_code, next_reading);
				readings_due.push_back(next_reading);
			end
			pending <= readings_due.size();
		end
	end

endmodule

[tb/sv/periodic_temp_sensor_converter_unit_tb.sv]
// testbench top for periodic_temp_sensor_converter_unit: clock, reset, register writes and
// item beats, directed then random, with random idling on both channels
// depends on ptsc_pkg and periodic_temp_sensor_converter_unit_checker

module periodic_temp_sensor_converter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ptsc_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int         ITEM_TOTAL  = 1650;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [3:0]               paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	logic [1:0]               command = '0;
	logic [CODE_W-1:0]        sample_code = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic                     start_conversion;
	logic signed [TEMP_W-1:0] temperature;
	logic                     fresh;
	logic [CODE_W-1:0]        last_code;
	logic                     used_calibration;

	int errors;
	int pending;
	int checked;
	int items_sent = 0;
	int conversions = 0;
	int settings = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	periodic_temp_sensor_converter_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall),
		.command(command), .sample_code(sample_code),
		.result_valid(result_valid), .result_stall(result_stall),
		.start_conversion(start_conversion), .temperature(temperature), .fresh(fresh),
		.last_code(last_code), .used_calibration(used_calibration)
	);

	periodic_temp_sensor_converter_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.pready(pready),
		.item_valid(item_valid), .item_stall(item_stall),
		.command(command), .sample_code(sample_code),
		.result_valid(result_valid), .result_stall(result_stall),
		.start_conversion(start_conversion), .temperature(temperature), .fresh(fresh),
		.last_code(last_code), .used_calibration(used_calibration),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	task automatic send_item(input logic [1:0] cmd, input logic [CODE_W-1:0] code);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		sample_code <= code;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
		if (cmd == CMD_DONE)
			conversions++;
	endtask

	// lets the last beat go and waits until every result beat is back
	task automatic drain;
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic en, input logic [15:0] itv, input logic [11:0] lo,
			input logic [11:0] hi, input int skip_pct);
		drain();
		if ($urandom_range(0, 99) >= skip_pct)
			write_reg(REG_INTERVAL, {16'($urandom()), itv});
		if ($urandom_range(0, 99) >= skip_pct)
			write_reg(REG_CAL_LOW, {20'($urandom()), lo});
		if ($urandom_range(0, 99) >= skip_pct)
			write_reg(REG_CAL_HIGH, {20'($urandom()), hi});
		if ($urandom_range(0, 99) >= skip_pct)
			write_reg(REG_ENABLE, {31'($urandom()), en});
		settings++;
	endtask

	task automatic random_setting;
		int lo;
		int hi;
		logic [15:0] itv;
		case ($urandom_range(0, 9))
			0:       itv = 16'd0;
			1:       itv = 16'hFFFF;
			2, 3:    itv = 16'($urandom_range(7, 40));
			default: itv = 16'($urandom_range(1, 6));
		endcase
		case ($urandom_range(0, 4))
			0: begin
				lo = 0;
				hi = $urandom_range(0, 4095);
			end
			1: begin
				lo = $urandom_range(1, 4094);
				hi = $urandom_range(lo + 1, 4095);
			end
			2: begin
				lo = $urandom_range(1, 4000);
				hi = lo + $urandom_range(1, 8);
			end
			3: begin
				lo = $urandom_range(0, 4095);
				hi = $urandom_range(0, lo);
			end
			default: begin
				lo = $urandom_range(0, 4095);
				hi = $urandom_range(0, 4095);
			end
		endcase
		configure(($urandom_range(0, 99) < 85), itv, 12'(lo), 12'(hi), 25);
	endtask

	task automatic random_item;
		int pick;
		logic [1:0] cmd;
		logic [CODE_W-1:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			cmd = CMD_TICK;
		else if (pick < 65)
			cmd = CMD_DONE;
		else if (pick < 92)
			cmd = CMD_POLL;
		else
			cmd = CMD_UNKNOWN;
		if ($urandom_range(0, 9) == 0)
			code = $urandom_range(0, 1) ? '1 : '0;
		else
			code = CODE_W'($urandom());
		send_item(cmd, code);
	endtask

	initial begin
		#20ms;
		$display("periodic_temp_sensor_converter_unit_tb: done, errors");
		$finish;
	end

	initial begin
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 19;
		recv_idle_pct = 71;

		// disabled: everything but the poll is ignored
		send_item(CMD_TICK, '0);
		send_item(CMD_DONE, '1);
		send_item(CMD_POLL, '0);
		send_item(CMD_UNKNOWN, 12'h5A5);

		// datasheet line, zero interval falls back to the default
		configure(1'b1, 16'd0, 12'd0, 12'd0, 0);
		send_item(CMD_TICK, '0);
		send_item(CMD_TICK, '1);
		send_item(CMD_DONE, '0);
		send_item(CMD_DONE, '1);
		send_item(CMD_POLL, '0);
		send_item(CMD_POLL, '0);
		send_item(CMD_UNKNOWN, '1);

		// widest valid calibration span, request on every tick
		configure(1'b1, 16'd1, 12'd1, 12'd4095, 0);
		send_item(CMD_TICK, '0);
		send_item(CMD_TICK, '0);
		send_item(CMD_DONE, '0);
		send_item(CMD_DONE, '1);
		send_item(CMD_POLL, '0);

		// narrow spans saturate both ways
		configure(1'b1, 16'hFFFF, 12'd4094, 12'd4095, 0);
		send_item(CMD_DONE, '0);
		send_item(CMD_DONE, '1);
		send_item(CMD_TICK, '0);
		send_item(CMD_TICK, '0);
		configure(1'b1, 16'd2, 12'd1, 12'd2, 0);
		send_item(CMD_DONE, '1);
		send_item(CMD_DONE, '0);

		// equal and reversed calibration words are invalid
		configure(1'b1, 16'd3, 12'd2000, 12'd2000, 0);
		send_item(CMD_DONE, 12'd1234);
		configure(1'b1, 16'd3, 12'd3000, 12'd1000, 0);
		send_item(CMD_DONE, 12'h800);
		send_item(CMD_POLL, '0);

		while (items_sent < ITEM_TOTAL) begin
			if (items_sent < 550) begin
				send_idle_pct = 19;
				recv_idle_pct = 71;
			end else if (items_sent < 1100) begin
				send_idle_pct = 71;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_setting();
			n = $urandom_range(30, 110);
			repeat (n) random_item();
		end

		drain();
		$display("covered %0d item beats with %0d conversions over %0d register settings",
			items_sent, conversions, settings);
		$display("%0d result beats compared, %0d mismatches", checked, errors);
		if (errors == 0 && pending == 0)
			$display("periodic_temp_sensor_converter_unit_tb: done, clean");
		else
			$display("periodic_temp_sensor_converter_unit_tb: done, errors");
		$finish;
	end

endmodule

[periodic_temp_sensor_converter_unit.f]
sv/ptsc_pkg.sv
sv/periodic_temp_sensor_converter_unit.sv
tb/sv/periodic_temp_sensor_converter_unit_checker.sv
tb/sv/periodic_temp_sensor_converter_unit_tb.sv
